### rtl/gbac_pkg.sv
// Shared types and constants for the gyro bias autocalibration block.
package gbac_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 15;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STILL_THRESHOLD   = 2'd0,
    CFG_STILL_COUNT_LIMIT = 2'd1,
    CFG_WRAP_GUARD        = 2'd2
  } cfg_reg_t;

  localparam level_t STILL_THRESHOLD_RESET = 15'h001a;
  localparam count_t STILL_COUNT_LIMIT_RESET = 8'h80;
  localparam level_t WRAP_GUARD_RESET = 15'h0400;

  localparam rate_t RATE_MIN = 16'sh8000;
  localparam rate_t RATE_MAX = 16'sh7fff;

  typedef struct packed {
    level_t still_threshold;
    level_t wrap_guard;
  } axis_cfg_t;

endpackage

### rtl/gbac_in_if.sv
// Sample channel: one three-axis gyro sample per item.
interface gbac_in_if
  import gbac_pkg::*;
;
  logic  valid;
  logic  ready;
  rate_t rate_x;
  rate_t rate_y;
  rate_t rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

### rtl/gbac_out_if.sv
// Result channel: corrected rates and the recalibration flag per item.
interface gbac_out_if
  import gbac_pkg::*;
;
  logic  valid;
  logic  ready;
  rate_t corr_x;
  rate_t corr_y;
  rate_t corr_z;
  logic  offsets_updated;

  modport source (output valid, output corr_x, output corr_y, output corr_z,
                  output offsets_updated, input ready);
  modport sink (input valid, input corr_x, input corr_y, input corr_z,
                input offsets_updated, output ready);
endinterface

### rtl/gbac_axis.sv
// Per-axis motion test, offset correction with sign-flip saturation and new offset.
module gbac_axis
  import gbac_pkg::*;
(
  input  rate_t     sample,
  input  rate_t     reference,
  input  rate_t     offset,
  input  axis_cfg_t cfg,
  output logic      moved,
  output rate_t     corr,
  output rate_t     avg
);

  logic [RATE_W-1:0] diff;
  logic [RATE_W-1:0] diff_mag;
  logic [RATE_W-1:0] sample_mag;
  logic [RATE_W-1:0] raw_corr;
  logic [RATE_W:0]   sum;
  logic              flip;

  always_comb begin
    diff       = sample - reference;
    diff_mag   = diff[RATE_W-1] ? (~diff + 1'b1) : diff;
    moved      = diff_mag > {1'b0, cfg.still_threshold};

    raw_corr   = sample - offset;
    sample_mag = sample[RATE_W-1] ? (~sample + 1'b1) : sample;
    flip       = (raw_corr[RATE_W-1] != sample[RATE_W-1]) &&
                 (sample_mag > {1'b0, cfg.wrap_guard});
    if (flip) begin
      corr = sample[RATE_W-1] ? RATE_MIN : RATE_MAX;
    end else begin
      corr = rate_t'(raw_corr);
    end

    // floor of the halved 17-bit sum
    sum = {reference[RATE_W-1], reference} + {sample[RATE_W-1], sample};
    avg = rate_t'(sum[RATE_W:1]);
  end

endmodule

### rtl/gyro_bias_autocalibration.sv
// Gyro bias autocalibration top level: stillness detection, offset tracking, correction.
//
// Takes one three-axis sample per cycle while results drain and returns one
// result per sample, in the cycle after acceptance, through a single output
// register; a sample is accepted whenever that register is empty or drained in
// the same cycle, so the rate is one item per clock unless stalled. Each sample is checked
// against the held reference: a change beyond still_threshold on any axis
// replaces the reference and restarts the stillness count. Once the count
// exceeds still_count_limit, the offsets are set to the mean of reference
// and sample and that item returns zeros with offsets_updated set. Other
// items return sample minus offset, saturated to full scale when the
// correction flips the sign of a sample larger than wrap_guard. With a
// limit of 255 the offsets are never recomputed. Writes to register index 3
// are ignored; configure only while no item is in flight.
module gyro_bias_autocalibration
  import gbac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_wdata,
  gbac_in_if.sink    samples,
  gbac_out_if.source results
);

  level_t    still_threshold;
  count_t    still_count_limit;
  level_t    wrap_guard;
  axis_cfg_t axis_cfg;

  rate_t  reference [NUM_AXES];
  rate_t  offset [NUM_AXES];
  count_t still_counter;
  count_t still_counter_next;

  rate_t sample [NUM_AXES];
  rate_t corr [NUM_AXES];
  rate_t avg [NUM_AXES];
  logic [NUM_AXES-1:0] moved;

  logic in_accept;
  logic moved_any;
  logic recal;

  assign axis_cfg = '{still_threshold: still_threshold, wrap_guard: wrap_guard};

  assign sample[0] = samples.rate_x;
  assign sample[1] = samples.rate_y;
  assign sample[2] = samples.rate_z;

  assign samples.ready = !results.valid || results.ready;
  assign in_accept = samples.valid && samples.ready;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    gbac_axis u_axis (
      .sample    (sample[a]),
      .reference (reference[a]),
      .offset    (offset[a]),
      .cfg       (axis_cfg),
      .moved     (moved[a]),
      .corr      (corr[a]),
      .avg       (avg[a])
    );
  end

  assign moved_any = |moved;
  assign recal = !moved_any && (still_counter > still_count_limit);
  assign still_counter_next = (moved_any || recal) ? count_t'(1) : still_counter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold   <= STILL_THRESHOLD_RESET;
      still_count_limit <= STILL_COUNT_LIMIT_RESET;
      wrap_guard        <= WRAP_GUARD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STILL_THRESHOLD:   still_threshold   <= level_t'(cfg_wdata);
        CFG_STILL_COUNT_LIMIT: still_count_limit <= count_t'(cfg_wdata);
        CFG_WRAP_GUARD:        wrap_guard        <= level_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_counter <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        reference[a] <= '0;
        offset[a]    <= '0;
      end
    end else if (in_accept) begin
      still_counter <= still_counter_next;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (moved_any) begin
          reference[a] <= sample[a];
        end
        if (recal) begin
          offset[a] <= avg[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (in_accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      results.corr_x          <= recal ? '0 : corr[0];
      results.corr_y          <= recal ? '0 : corr[1];
      results.corr_z          <= recal ? '0 : corr[2];
      results.offsets_updated <= recal;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> results.valid)
    else $error("accepted item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |-> !samples.ready)
    else $error("sample accepted while result stalled");

  a_motion_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && moved_any |=> still_counter == count_t'(1))
    else $error("stillness count not restarted on motion");

  a_recal_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && recal |=> still_counter == count_t'(1) && results.offsets_updated)
    else $error("recalibration did not restart count or flag result");

  a_recal_zero: assert property (@(posedge clk) disable iff (rst)
    in_accept && recal |=> results.corr_x == '0 && results.corr_y == '0 &&
                           results.corr_z == '0)
    else $error("recalibration result not zero");

endmodule
